/* hw/rtl/nmea_sentence_framer_top_macros.svh */
// Assertion helpers used by the framer top-level RTL.
// Each macro expects clk and rst_n in scope.
`ifndef NMEA_SENTENCE_FRAMER_TOP_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_TOP_MACROS_SVH

// Same-cycle implication.
`define NSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// Next-cycle implication.
`define NSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

/* hw/rtl/nsf_pkg.sv */
`timescale 1ns / 1ps
package nsf_pkg;

    localparam int NSF_MAX_SENTENCE = 128;
    localparam int HDR_LEN          = 6;
    localparam int NUM_TYPES        = 6;
    localparam int BODY_LEN_W       = 7;
    localparam int KIND_W           = 3;
    localparam int TDATA_W          = 16;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_Z      = 8'h5A;

    // Sentence addresses, first character in the high byte.
    localparam logic [39:0] TYPE_NAMES [NUM_TYPES] = '{
        "GPGGA", "GPGLL", "GPGSA", "GPRMC", "GPGSV", "GPVTG"
    };

    typedef enum logic [1:0] {
        EV_ACCEPTED = 2'd0,
        EV_BAD_SUM  = 2'd1,
        EV_TOO_LONG = 2'd2,
        EV_UNKNOWN  = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic       is_nl;
        logic       is_cr;
        logic       is_dollar;
        logic       is_star;
        logic       is_body;
        logic       is_hex;
        logic [3:0] hex_val;
    } char_class_t;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] code;
    } type_match_t;

endpackage

/* hw/rtl/nsf_classify.sv */
`timescale 1ns / 1ps
module nsf_classify (
    input  logic [7:0]           rx_byte,
    output nsf_pkg::char_class_t cls
);
    import nsf_pkg::*;

    logic is_digit;
    logic is_upper;
    logic is_af;

    assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
    assign is_upper = (rx_byte >= CH_A) && (rx_byte <= CH_Z);
    assign is_af    = (rx_byte >= CH_A) && (rx_byte <= CH_F);

    always_comb
    begin
        cls.is_nl     = (rx_byte == CH_NL);
        cls.is_cr     = (rx_byte == CH_CR);
        cls.is_dollar = (rx_byte == CH_DOLLAR);
        cls.is_star   = (rx_byte == CH_STAR);
        cls.is_body   = is_digit || is_upper || (rx_byte == CH_COMMA)
                        || (rx_byte == CH_PERIOD);
        cls.is_hex    = is_digit || is_af;
        // 'A'..'F' have low nibbles 1..6; add 9 to land on 10..15
        cls.hex_val   = is_digit ? rx_byte[3:0] : (rx_byte[3:0] + 4'd9);
    end

endmodule

/* hw/rtl/nsf_type_match.sv */
`timescale 1ns / 1ps
module nsf_type_match (
    input  logic [7:0]           header [nsf_pkg::HDR_LEN],
    input  logic                 long_enough,
    output nsf_pkg::type_match_t match
);
    import nsf_pkg::*;

    logic [39:0] prefix;

    assign prefix = {header[0], header[1], header[2], header[3], header[4]};

    always_comb
    begin
        match.hit  = 1'b0;
        match.code = '0;
        // Scan from the top so the lowest matching code wins
        for (int t = NUM_TYPES - 1; t >= 0; t--)
        begin
            if (prefix == TYPE_NAMES[t])
            begin
                match.hit  = 1'b1;
                match.code = KIND_W'(t);
            end
        end
        if (!long_enough || (header[HDR_LEN-1] != CH_COMMA))
        begin
            match.hit  = 1'b0;
            match.code = '0;
        end
    end

endmodule

/* hw/rtl/nmea_sentence_framer_top.sv */
`timescale 1ns / 1ps
// NMEA 0183 sentence framer. Feed one received character per request on s_axis;
// the block takes a byte every clock cycle while no result stalls it, and answers
// a completed, failed or overlong sentence with one request on m_axis whose tvalid
// rises after the closing byte has passed the input register and then the result
// register. Bytes that end no sentence give no result. s_axis_tready drops only
// while a result waits in the result register and m_axis_tready is low. Illegal bytes
// drop sync without a result; after a bad checksum every further newline repeats it.
`include "nmea_sentence_framer_top_macros.svh"
module nmea_sentence_framer_top #(
    parameter int MAX_SENTENCE = nsf_pkg::NSF_MAX_SENTENCE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] rx_byte
    input  logic [7:0]                  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [1:0] event_kind, [4:2] sentence_kind, [11:5] body_length, [12] in_sync
    output logic [nsf_pkg::TDATA_W-1:0] m_axis_tdata
);
    import nsf_pkg::*;

    localparam int CNT_W = $clog2(MAX_SENTENCE);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SENTENCE - 1);
    localparam logic [CNT_W-1:0] CNT_HDR   = CNT_W'(HDR_LEN);

    typedef enum logic [2:0] {
        PH_WAIT_NL,
        PH_DOLLAR,
        PH_BODY,
        PH_HEX_HI,
        PH_HEX_LO,
        PH_END_NL
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      xor_reg, xor_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic            sync_reg, sync_next;
    logic [7:0]      header_reg [HDR_LEN];

    logic            in_valid_reg, in_valid_next;
    logic [7:0]      byte_reg;

    logic            out_valid_reg, out_valid_next;
    event_kind_t     ev_reg, ev_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BODY_LEN_W-1:0] len_reg, len_next;
    logic            osync_reg, osync_next;

    logic            fire;
    logic            emit;
    logic            hdr_write;
    logic [BODY_LEN_W+CNT_W-1:0] count_ext;
    char_class_t     cls;
    type_match_t     match;

    nsf_classify u_classify (
        .rx_byte (byte_reg),
        .cls     (cls)
    );

    nsf_type_match u_type_match (
        .header      (header_reg),
        .long_enough (count_reg >= CNT_HDR),
        .match       (match)
    );

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign count_ext     = {{BODY_LEN_W{1'b0}}, count_reg};

    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        count_next = count_reg;
        sync_next  = sync_reg;
        emit       = 1'b0;
        hdr_write  = 1'b0;
        ev_next    = EV_ACCEPTED;
        kind_next  = '0;
        len_next   = count_ext[BODY_LEN_W-1:0];
        osync_next = sync_reg;
        case (phase_reg)
            PH_WAIT_NL:
            begin
                if (cls.is_nl)
                    phase_next = PH_DOLLAR;
                else
                    sync_next = 1'b0;
            end
            PH_DOLLAR:
            begin
                if (cls.is_dollar)
                begin
                    phase_next = PH_BODY;
                    xor_next   = '0;
                    count_next = '0;
                end
                else
                begin
                    phase_next = PH_WAIT_NL;
                    sync_next  = 1'b0;
                end
            end
            PH_BODY:
            begin
                if (cls.is_star)
                    phase_next = PH_HEX_HI;
                else if (cls.is_body && (count_reg == CNT_LIMIT))
                begin
                    phase_next = PH_WAIT_NL;
                    sync_next  = 1'b0;
                    emit       = 1'b1;
                    ev_next    = EV_TOO_LONG;
                    osync_next = 1'b0;
                end
                else if (cls.is_body)
                begin
                    hdr_write  = (count_reg < CNT_HDR);
                    count_next = count_reg + 1'b1;
                    xor_next   = xor_reg ^ byte_reg;
                end
                else
                begin
                    phase_next = PH_WAIT_NL;
                    sync_next  = 1'b0;
                end
            end
            PH_HEX_HI:
            begin
                if (cls.is_hex)
                begin
                    xor_next   = xor_reg ^ {cls.hex_val, 4'h0};
                    phase_next = PH_HEX_LO;
                end
                else
                begin
                    phase_next = PH_WAIT_NL;
                    sync_next  = 1'b0;
                end
            end
            PH_HEX_LO:
            begin
                if (cls.is_hex)
                begin
                    xor_next   = xor_reg ^ {4'h0, cls.hex_val};
                    phase_next = PH_END_NL;
                end
                else
                begin
                    phase_next = PH_WAIT_NL;
                    sync_next  = 1'b0;
                end
            end
            PH_END_NL:
            begin
                if (cls.is_cr)
                    phase_next = PH_END_NL;
                else if (cls.is_nl && (xor_reg != '0))
                begin
                    // hold phase and sync so later newlines repeat the report
                    emit    = 1'b1;
                    ev_next = EV_BAD_SUM;
                end
                else if (cls.is_nl)
                begin
                    emit       = 1'b1;
                    sync_next  = 1'b1;
                    phase_next = PH_DOLLAR;
                    osync_next = 1'b1;
                    ev_next    = match.hit ? EV_ACCEPTED : EV_UNKNOWN;
                    kind_next  = match.hit ? match.code : '0;
                end
                else
                begin
                    phase_next = PH_WAIT_NL;
                    sync_next  = 1'b0;
                end
            end
            default:
            begin
                phase_next = PH_WAIT_NL;
                sync_next  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = emit;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT_NL;
            xor_reg       <= '0;
            count_reg     <= '0;
            sync_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ev_reg        <= EV_ACCEPTED;
            kind_reg      <= '0;
            len_reg       <= '0;
            osync_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                xor_reg   <= xor_next;
                count_reg <= count_next;
                sync_reg  <= sync_next;
            end
            if (fire && emit)
            begin
                ev_reg    <= ev_next;
                kind_reg  <= kind_next;
                len_reg   <= len_next;
                osync_reg <= osync_next;
            end
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            byte_reg <= s_axis_tdata;
        if (fire && hdr_write)
            header_reg[count_reg[2:0]] <= byte_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - 13){1'b0}}, osync_reg, len_reg, kind_reg, ev_reg};

    `NSF_ASSERT_NOW(a_no_overwrite, out_valid_reg && !m_axis_tready, !fire)
    `NSF_ASSERT_NOW(a_sync_phase, sync_reg, phase_reg != PH_WAIT_NL)
    `NSF_ASSERT_NOW(a_count_limit, 1'b1, count_reg <= CNT_LIMIT)
    `NSF_ASSERT_NEXT(a_long_drops, fire && emit && (ev_next == EV_TOO_LONG),
        !sync_reg && !osync_reg && (phase_reg == PH_WAIT_NL))

endmodule

/* verif/nmea_sentence_framer_checker.sv */
`timescale 1ns / 1ps
module nmea_sentence_framer_checker #(
    parameter int MAX_SENTENCE = nsf_pkg::NSF_MAX_SENTENCE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [nsf_pkg::TDATA_W-1:0] m_axis_tdata,
    output int                          mismatches,
    output int                          outstanding
);
    import nsf_pkg::*;

    typedef enum logic [2:0] {
        SEEK_NL,
        SEEK_DOLLAR,
        IN_BODY,
        SUM_HI,
        SUM_LO,
        SEEK_END
    } framer_phase_t;

    typedef struct packed {
        event_kind_t ev;
        logic [2:0]  kind;
        logic [6:0]  len;
        logic        sync;
    } framer_result_t;

    framer_phase_t  phase;
    logic [7:0]     sum;
    logic [10:0]    count;
    logic [7:0]     hdr [HDR_LEN];
    logic           sync;
    framer_result_t expected_events [$];

    function automatic bit is_body_char(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_A && c <= CH_Z) ||
               c == CH_COMMA || c == CH_PERIOD;
    endfunction

    // 16 marks a byte that is not an upper-case hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return 5'(c - CH_0);
        if (c >= CH_A && c <= CH_F)
            return 5'(c - CH_A + 8'd10);
        return 5'd16;
    endfunction

    // NUM_TYPES means no sentence type matched
    function automatic int header_type();
        logic [39:0] name;
        name = {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4]};
        if (count < HDR_LEN || hdr[5] != CH_COMMA)
            return NUM_TYPES;
        for (int t = 0; t < NUM_TYPES; t++)
        begin
            if (name == TYPE_NAMES[t])
                return t;
        end
        return NUM_TYPES;
    endfunction

    task automatic post_event(input event_kind_t ev, input logic [2:0] kind);
        framer_result_t r;
        r.ev   = ev;
        r.kind = kind;
        r.len  = count[6:0];
        r.sync = sync;
        expected_events.push_back(r);
    endtask

    task automatic frame_byte(input logic [7:0] c);
        logic [4:0] nib;
        int         code;
        bit         drop;
        drop = 1'b0;
        nib  = nibble_of(c);
        case (phase)
            SEEK_NL:
                if (c == CH_NL)
                    phase = SEEK_DOLLAR;
                else
                    drop = 1'b1;
            SEEK_DOLLAR:
                if (c == CH_DOLLAR)
                begin
                    phase = IN_BODY;
                    sum   = 8'h00;
                    count = '0;
                end
                else
                    drop = 1'b1;
            IN_BODY:
                if (c == CH_STAR)
                    phase = SUM_HI;
                else if (!is_body_char(c))
                    drop = 1'b1;
                else if (count >= MAX_SENTENCE - 1)
                begin
                    // overflow reports with sync already dropped
                    phase = SEEK_NL;
                    sync  = 1'b0;
                    post_event(EV_TOO_LONG, 3'd0);
                end
                else
                begin
                    if (count < HDR_LEN)
                        hdr[count] = c;
                    count = count + 1'b1;
                    sum   = sum ^ c;
                end
            SUM_HI:
                if (nib > 5'd15)
                    drop = 1'b1;
                else
                begin
                    sum   = sum ^ {nib[3:0], 4'h0};
                    phase = SUM_LO;
                end
            SUM_LO:
                if (nib > 5'd15)
                    drop = 1'b1;
                else
                begin
                    sum   = sum ^ {4'h0, nib[3:0]};
                    phase = SEEK_END;
                end
            SEEK_END:
                if (c == CH_CR)
                    drop = 1'b0;
                else if (c != CH_NL)
                    drop = 1'b1;
                else if (sum != 8'h00)
                    // hold phase and sync: each further newline repeats this
                    post_event(EV_BAD_SUM, 3'd0);
                else
                begin
                    code  = header_type();
                    sync  = 1'b1;
                    phase = SEEK_DOLLAR;
                    if (code < NUM_TYPES)
                        post_event(EV_ACCEPTED, 3'(code));
                    else
                        post_event(EV_UNKNOWN, 3'd0);
                end
            default:
                drop = 1'b1;
        endcase
        if (drop)
        begin
            phase = SEEK_NL;
            sync  = 1'b0;
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_result();
        framer_result_t r;
        if (expected_events.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
            mismatches++;
        end
        else
        begin
            r = expected_events.pop_front();
            check_field("event_kind", 16'(r.ev), 16'(m_axis_tdata[1:0]));
            check_field("sentence_kind", 16'(r.kind), 16'(m_axis_tdata[4:2]));
            check_field("body_length", 16'(r.len), 16'(m_axis_tdata[11:5]));
            check_field("in_sync", 16'(r.sync), 16'(m_axis_tdata[12]));
            check_field("tdata padding", 16'd0, 16'(m_axis_tdata[15:13]));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = SEEK_NL;
            sum   = 8'h00;
            count = '0;
            sync  = 1'b0;
            for (int i = 0; i < HDR_LEN; i++)
                hdr[i] = 8'h00;
            expected_events.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // retire before predicting: a result never belongs to this edge's byte
            if (m_axis_tvalid && m_axis_tready)
                compare_result();
            if (s_axis_tvalid && s_axis_tready)
                frame_byte(s_axis_tdata);
            outstanding = expected_events.size();
        end
    end

endmodule

/* verif/nmea_sentence_framer_top_tb.sv */
`timescale 1ns / 1ps
module nmea_sentence_framer_top_tb;
    import nsf_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BYTES = 1100;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = 8'h00;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    int                  fail_count;
    int                  pending;
    int                  cycles        = 0;
    int                  sent_bytes    = 0;
    bit                  steady        = 1'b0;
    bit                  synced        = 1'b0;

    nmea_sentence_framer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    nmea_sentence_framer_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (fail_count),
        .outstanding   (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 19);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("nmea_sentence_framer_top_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_body_char();
        int r;
        r = $urandom_range(37);
        if (r < 10)
            return CH_0 + 8'(r);
        if (r < 36)
            return CH_A + 8'(r - 10);
        return (r == 36) ? CH_COMMA : CH_PERIOD;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? CH_0 + 8'(nib) : CH_A + 8'(nib - 4'd10);
    endfunction

    function automatic string pick_head(input int k);
        case (k)
            0:       return "GPGGA,";
            1:       return "GPGLL,";
            2:       return "GPGSA,";
            3:       return "GPRMC,";
            4:       return "GPGSV,";
            5:       return "GPVTG,";
            6:       return "GPGGB,";
            7:       return "GPRMC.";
            8:       return "GN";
            default: return "";
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 19)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        sent_bytes++;
    endtask

    // bad_pos < 0: no stray byte; otherwise bad_char goes in before that frame byte
    task automatic send_sentence(input string head, input int extra, input logic [7:0] sum_err,
                                 input bit cr, input int bad_pos, input logic [7:0] bad_char);
        logic [7:0] frame [$];
        logic [7:0] sum;
        logic [7:0] c;
        int         body_len;
        if (!synced)
        begin
            // an illegal byte then newline reaches the dollar phase from anywhere
            send_byte("#");
            send_byte(CH_NL);
        end
        sum = 8'h00;
        frame.push_back(CH_DOLLAR);
        for (int i = 0; i < head.len(); i++)
        begin
            c = head[i];
            frame.push_back(c);
            sum ^= c;
        end
        for (int i = 0; i < extra; i++)
        begin
            c = rand_body_char();
            frame.push_back(c);
            sum ^= c;
        end
        body_len = frame.size() - 1;
        sum ^= sum_err;
        frame.push_back(CH_STAR);
        frame.push_back(hex_char(sum[7:4]));
        frame.push_back(hex_char(sum[3:0]));
        if (cr)
            frame.push_back(CH_CR);
        frame.push_back(CH_NL);
        if (bad_pos >= frame.size())
            bad_pos = frame.size() - 1;
        foreach (frame[i])
        begin
            if (i == bad_pos)
                send_byte(bad_char);
            send_byte(frame[i]);
        end
        synced = (sum_err == 8'h00) && (bad_pos < 0) && (body_len < NSF_MAX_SENTENCE);
    endtask

    initial
    begin
        int start;
        int done;
        int repeats;
        int extra;
        bit paused;
        logic [7:0] sum_err;
        int bad_pos;

        paused = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // every sentence type, with and without carriage return
        send_sentence("GPGGA,1,2.5", 0, 8'h00, 1'b1, -1, 8'h00);
        send_sentence("GPGLL,", 0, 8'h00, 1'b0, -1, 8'h00);
        send_sentence("GPGSA,", 0, 8'h00, 1'b1, -1, 8'h00);
        send_sentence("GPRMC,A", 0, 8'h00, 1'b0, -1, 8'h00);
        send_sentence("GPGSV,3", 0, 8'h00, 1'b1, -1, 8'h00);
        send_sentence("GPVTG,.", 0, 8'h00, 1'b0, -1, 8'h00);
        // unknown names, missing comma, empty and short bodies, zero checksum
        send_sentence("GPXYZ,", 0, 8'h00, 1'b0, -1, 8'h00);
        send_sentence("GPGGA.", 0, 8'h00, 1'b0, -1, 8'h00);
        send_sentence("", 0, 8'h00, 1'b1, -1, 8'h00);
        send_sentence("GPGG", 0, 8'h00, 1'b0, -1, 8'h00);
        send_sentence("AA", 0, 8'h00, 1'b0, -1, 8'h00);
        // longest body that fits, then one character more
        send_sentence("GPRMC,", 121, 8'h00, 1'b0, -1, 8'h00);
        send_sentence("GPRMC,", 122, 8'h00, 1'b0, -1, 8'h00);
        // bad checksum, repeated by every further newline
        send_sentence("GPVTG,", 4, 8'h01, 1'b1, -1, 8'h00);
        send_byte(CH_NL);
        send_byte(CH_CR);
        send_byte(CH_NL);
        synced = 1'b0;
        // a stray byte in each phase of the frame drops sync
        send_sentence("GPGSA,1", 0, 8'h00, 1'b0, 0, "A");
        send_sentence("GPGSA,1", 0, 8'h00, 1'b0, 3, "a");
        send_sentence("GPGSA,1", 0, 8'h00, 1'b0, 9, "G");
        send_sentence("GPGSA,1", 0, 8'h00, 1'b0, 10, "a");
        send_sentence("GPGSA,1", 0, 8'h00, 1'b0, 11, "X");
        send_sentence("GPGSA,1", 0, 8'h00, 1'b0, 5, 8'h00);
        send_sentence("GPGSA,1", 0, 8'h00, 1'b0, 8, 8'hFF);

        start = sent_bytes;
        while (sent_bytes - start < RANDOM_BYTES)
        begin
            done   = sent_bytes - start;
            steady = (done >= 500 && done < 800);
            if (!paused && done >= 1000)
            begin
                // hold the sender until the block has answered everything
                s_axis_tvalid = 1'b0;
                wait (pending == 0);
                @(negedge clk);
                paused = 1'b1;
            end
            if ($urandom_range(99) < 6)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(255)));
                synced = 1'b0;
            end
            else
            begin
                extra   = ($urandom_range(39) == 0) ? $urandom_range(115, 125)
                                                    : $urandom_range(0, 24);
                sum_err = ($urandom_range(99) < 10) ? 8'($urandom_range(1, 255)) : 8'h00;
                bad_pos = ($urandom_range(99) < 8) ? $urandom_range(0, 40) : -1;
                send_sentence(pick_head(($urandom_range(99) < 75) ? $urandom_range(5)
                                                                   : $urandom_range(6, 9)),
                              extra, sum_err, 1'($urandom_range(1)), bad_pos,
                              8'($urandom_range(255)));
                if (sum_err != 8'h00 && bad_pos < 0)
                begin
                    repeats = $urandom_range(0, 2);
                    repeat (repeats)
                        send_byte(CH_NL);
                end
            end
        end
        steady = 1'b0;

        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("nmea_sentence_framer_top_tb: PASS");
        else
            $display("nmea_sentence_framer_top_tb: FAIL");
        $finish;
    end

endmodule
